/* design/rlog_pkg.sv */
package rlog_pkg;

  // Command codes on the input channel
  typedef enum logic [1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_END    = 2'd1,
    CMD_RECORD = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  // Status codes on the result channel
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_WAIT    = 3'd1,
    ST_FULL    = 3'd2,
    ST_OUTSIDE = 3'd3,
    ST_NOBEGIN = 3'd4
  } status_t;

  // Disk actions requested by a result
  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_COPY    = 2'd1,
    ACT_HEADER  = 2'd2,
    ACT_INSTALL = 2'd3
  } action_t;

  // Cache pin requests
  typedef enum logic [1:0] {
    HOLD_NONE  = 2'd0,
    HOLD_PIN   = 2'd1,
    HOLD_UNPIN = 2'd2
  } hold_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_LOG_START  = 2'd0,
    REG_LOG_LENGTH = 2'd1,
    REG_MAX_PER_OP = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_EXEC,
    S_COPY,
    S_HDR_SET,
    S_INSTALL,
    S_HDR_CLEAR
  } state_t;

  // Active operation counter saturation point
  localparam logic [4:0] OPS_MAX = 5'd31;

  // Control broadcast to every cell of the table
  typedef struct packed {
    logic        shift;   // rotate entries one cell toward the head
    logic        cmp;     // capture key match
    logic [31:0] key;     // block number under search
  } cell_ctl_t;

endpackage

/* design/rlog_cell.sv */
module rlog_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  rlog_pkg::cell_ctl_t  ctl,
  input  logic                 occupied,
  input  logic                 wr_en,
  input  logic [31:0]          wr_data,
  input  logic [31:0]          nbr_data,
  output logic [31:0]          data,
  output logic                 hit
);

  logic [31:0] entry;

  // Rotate from the neighbor, or take a new entry
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      entry <= nbr_data;
    end else if (wr_en) begin
      entry <= wr_data;
    end
  end

  // Compare the held entry against the broadcast key
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctl.cmp) begin
      hit <= occupied && (entry == ctl.key);
    end
  end

  assign data = entry;

endmodule

/* design/redo_log_transaction_manager_core.sv */
// Redo log group-commit manager.
// Input channel s_axis_*: one item per request (begin, end, record block write).
// Result channel m_axis_*: one or more items per request; m_axis_tlast marks the
// final item of each request. A commit (end of the last active operation with a
// non-empty table) emits, in order, a copy per entry, a header write with the
// count, an install with unpin per entry and a header write with count zero.
// A request is taken in IDLE, the table compare is done in LOOKUP and the answer
// is loaded into the output register in EXEC once that register is free; no new
// request is taken until then. A commit rotates the table ring through its head
// cell twice, once in COPY and once in INSTALL, pausing while the receiver stalls.
// While m_axis_tready is low, the single output register keeps the waiting item
// and the sequencer pauses before loading another until it is taken.
// Reset (rst, synchronous) clears the operation counter, the entry count and
// the configuration to its defaults; table contents stay undefined until
// recorded. Configuration writes (cfg_we) take effect at once; the user must issue
// them only while no request is in flight, as the block does not enforce this.
module redo_log_transaction_manager_core #(
  parameter int LOG_CAPACITY = 30
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // cmd[1:0], block_number[33:2], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // status[2:0], action[4:3], source_block[36:5],
                                      // dest_block[68:37], header_count[73:69],
                                      // cache_hold[75:74], zero pad
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = (LOG_CAPACITY > 1) ? $clog2(LOG_CAPACITY) : 1;
  localparam int CW = $clog2(LOG_CAPACITY + 1);

  // Configuration registers
  logic [31:0] log_start;
  logic [31:0] log_length;
  logic [4:0]  max_per_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      log_start  <= 32'd0;
      log_length <= 32'd31;
      max_per_op <= 5'd10;
    end else if (cfg_we) begin
      case (rlog_pkg::reg_idx_t'(cfg_index))
        rlog_pkg::REG_LOG_START:  log_start  <= cfg_data;
        rlog_pkg::REG_LOG_LENGTH: log_length <= cfg_data;
        rlog_pkg::REG_MAX_PER_OP: max_per_op <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Control state
  rlog_pkg::state_t state, state_next;
  logic [CW-1:0] entry_count, entry_count_next;
  logic [4:0]    active_ops, active_ops_next;
  logic [IW-1:0] step, step_next;

  // Request capture
  rlog_pkg::cmd_t cmd_r;
  logic [31:0]    key;

  // Output register
  logic        out_valid;
  logic        out_load;
  logic        out_free;
  rlog_pkg::status_t o_status, out_status;
  rlog_pkg::action_t o_action, out_action;
  logic [31:0] o_src, o_dst, out_src, out_dst;
  logic [4:0]  o_hcnt, out_hcnt;
  rlog_pkg::hold_t o_hold, out_hold;
  logic        o_last, out_last;

  // Table ring
  rlog_pkg::cell_ctl_t ctl;
  logic        tab_wr;
  logic [31:0] cell_data [LOG_CAPACITY];
  logic [LOG_CAPACITY-1:0] cell_hit;
  logic        any_hit;
  logic [31:0] slot_addr;

  // Admission arithmetic
  logic [5:0]  ops_inc;
  logic [10:0] need;
  logic        rec_full;
  logic        step_pending;
  logic        step_wrap;

  genvar gi;
  generate
    for (gi = 0; gi < LOG_CAPACITY; gi++) begin : g_cell
      rlog_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .occupied (32'(entry_count) > gi),
        .wr_en    (tab_wr && (entry_count == CW'(gi))),
        .wr_data  (key),
        .nbr_data (cell_data[(gi + 1) % LOG_CAPACITY]),
        .data     (cell_data[gi]),
        .hit      (cell_hit[gi])
      );
    end
  endgenerate

  assign any_hit      = |cell_hit;
  assign slot_addr    = log_start + 32'd1 + 32'(step);
  assign ops_inc      = {1'b0, active_ops} + 6'd1;
  assign need         = 11'(ops_inc) * 11'(max_per_op) + 11'(entry_count);
  assign rec_full     = (32'(entry_count) >= LOG_CAPACITY) ||
                        ((33'(entry_count) + 33'd1) >= {1'b0, log_length});
  assign step_pending = 32'(step) < 32'(entry_count);
  assign step_wrap    = 32'(step) == (LOG_CAPACITY - 1);
  assign out_free     = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == rlog_pkg::S_IDLE);

  // Sequencer: next state and result selection
  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    active_ops_next  = active_ops;
    step_next        = step;
    out_load         = 1'b0;
    o_status         = rlog_pkg::ST_OK;
    o_action         = rlog_pkg::ACT_NONE;
    o_src            = 32'd0;
    o_dst            = 32'd0;
    o_hcnt           = 5'd0;
    o_hold           = rlog_pkg::HOLD_NONE;
    o_last           = 1'b1;
    tab_wr           = 1'b0;
    ctl.shift        = 1'b0;
    ctl.cmp          = 1'b0;
    ctl.key          = key;
    case (state)
      rlog_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = rlog_pkg::S_LOOKUP;
        end
      end
      rlog_pkg::S_LOOKUP: begin
        ctl.cmp    = 1'b1;
        state_next = rlog_pkg::S_EXEC;
      end
      rlog_pkg::S_EXEC: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = rlog_pkg::S_IDLE;
          case (cmd_r)
            rlog_pkg::CMD_BEGIN: begin
              if (active_ops == rlog_pkg::OPS_MAX || need > 11'(LOG_CAPACITY)) begin
                o_status = rlog_pkg::ST_WAIT;
              end else begin
                active_ops_next = active_ops + 5'd1;
              end
            end
            rlog_pkg::CMD_END: begin
              if (active_ops == 5'd0) begin
                o_status = rlog_pkg::ST_NOBEGIN;
              end else begin
                active_ops_next = active_ops - 5'd1;
                if (active_ops == 5'd1 && entry_count != '0) begin
                  out_load   = 1'b0;
                  step_next  = '0;
                  state_next = rlog_pkg::S_COPY;
                end
              end
            end
            rlog_pkg::CMD_RECORD: begin
              if (rec_full) begin
                o_status = rlog_pkg::ST_FULL;
              end else if (active_ops == 5'd0) begin
                o_status = rlog_pkg::ST_OUTSIDE;
              end else begin
                o_src = key;
                if (!any_hit) begin
                  tab_wr           = 1'b1;
                  entry_count_next = entry_count + CW'(1);
                  o_hold           = rlog_pkg::HOLD_PIN;
                end
              end
            end
            default: ;
          endcase
        end
      end
      rlog_pkg::S_COPY, rlog_pkg::S_INSTALL: begin
        // Emit one entry per step while entries remain, then finish the lap
        if (!step_pending || out_free) begin
          ctl.shift = 1'b1;
          out_load  = step_pending;
          o_last    = 1'b0;
          if (state == rlog_pkg::S_COPY) begin
            o_action = rlog_pkg::ACT_COPY;
            o_src    = cell_data[0];
            o_dst    = slot_addr;
          end else begin
            o_action = rlog_pkg::ACT_INSTALL;
            o_src    = slot_addr;
            o_dst    = cell_data[0];
            o_hold   = rlog_pkg::HOLD_UNPIN;
          end
          if (step_wrap) begin
            step_next  = '0;
            state_next = (state == rlog_pkg::S_COPY) ? rlog_pkg::S_HDR_SET
                                                     : rlog_pkg::S_HDR_CLEAR;
          end else begin
            step_next = step + IW'(1);
          end
        end
      end
      rlog_pkg::S_HDR_SET: begin
        if (out_free) begin
          out_load   = 1'b1;
          o_action   = rlog_pkg::ACT_HEADER;
          o_src      = log_start;
          o_dst      = log_start;
          o_hcnt     = 5'(entry_count);
          o_last     = 1'b0;
          state_next = rlog_pkg::S_INSTALL;
        end
      end
      rlog_pkg::S_HDR_CLEAR: begin
        if (out_free) begin
          out_load         = 1'b1;
          o_action         = rlog_pkg::ACT_HEADER;
          o_src            = log_start;
          o_dst            = log_start;
          entry_count_next = '0;
          state_next       = rlog_pkg::S_IDLE;
        end
      end
      default: state_next = rlog_pkg::S_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rlog_pkg::S_IDLE;
      entry_count <= '0;
      active_ops  <= 5'd0;
      step        <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      active_ops  <= active_ops_next;
      step        <= step_next;
      out_valid   <= out_load || (out_valid && !m_axis_tready);
    end
  end

  // Capture the accepted request
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_r <= rlog_pkg::cmd_t'(s_axis_tdata[1:0]);
      key   <= s_axis_tdata[33:2];
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= o_status;
      out_action <= o_action;
      out_src    <= o_src;
      out_dst    <= o_dst;
      out_hcnt   <= o_hcnt;
      out_hold   <= o_hold;
      out_last   <= o_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {4'd0, out_hold, out_hcnt, out_dst, out_src, out_action, out_status};

endmodule

/* test/redo_log_transaction_manager_core_tb.sv */
module redo_log_transaction_manager_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LOG_CAP = 30;
  localparam int IDLE_LIMIT = 3000;
  localparam int ITEM_TARGET = 470;

  // One expected item on the result channel
  typedef struct {
    rlog_pkg::status_t status;
    rlog_pkg::action_t action;
    logic [31:0]       src_blk;
    logic [31:0]       dst_blk;
    logic [4:0]        hdr_count;
    rlog_pkg::hold_t   hold;
    logic              last;
  } log_result_t;

  // Predicts the log manager and checks its result items in order
  class commit_tracker;
    logic [31:0] log_start;
    logic [31:0] region_len;
    logic [4:0]  per_op_max;
    logic [31:0] blocks[LOG_CAP];
    logic [4:0]  n_entries;
    logic [4:0]  n_active;
    log_result_t pending[$];
    int          errors;

    function new();
      log_start  = 32'd0;
      region_len = 32'd31;
      per_op_max = 5'd10;
      n_entries  = 5'd0;
      n_active   = 5'd0;
      errors     = 0;
    endfunction

    function void write_reg(rlog_pkg::reg_idx_t idx, logic [31:0] value);
      case (idx)
        rlog_pkg::REG_LOG_START:  log_start = value;
        rlog_pkg::REG_LOG_LENGTH: region_len = value;
        rlog_pkg::REG_MAX_PER_OP: per_op_max = value[4:0];
        default: ;
      endcase
    endfunction

    function void push(rlog_pkg::status_t st, rlog_pkg::action_t act, logic [31:0] src,
                       logic [31:0] dst, logic [4:0] hc, rlog_pkg::hold_t hd);
      log_result_t r;
      r.status    = st;
      r.action    = act;
      r.src_blk   = src;
      r.dst_blk   = dst;
      r.hdr_count = hc;
      r.hold      = hd;
      r.last      = 1'b0;
      pending.push_back(r);
    endfunction

    // Work out the result items caused by one accepted request
    function void note_request(rlog_pkg::cmd_t op, logic [31:0] blk);
      int  need;
      bit  found;
      case (op)
        rlog_pkg::CMD_BEGIN: begin
          need = int'(n_entries) + (int'(n_active) + 1) * int'(per_op_max);
          if (n_active >= rlog_pkg::OPS_MAX || need > LOG_CAP) begin
            push(rlog_pkg::ST_WAIT, rlog_pkg::ACT_NONE, 32'd0, 32'd0, 5'd0,
                 rlog_pkg::HOLD_NONE);
          end else begin
            n_active++;
            push(rlog_pkg::ST_OK, rlog_pkg::ACT_NONE, 32'd0, 32'd0, 5'd0,
                 rlog_pkg::HOLD_NONE);
          end
        end
        rlog_pkg::CMD_END: begin
          if (n_active == 5'd0) begin
            push(rlog_pkg::ST_NOBEGIN, rlog_pkg::ACT_NONE, 32'd0, 32'd0, 5'd0,
                 rlog_pkg::HOLD_NONE);
          end else begin
            n_active--;
            if (n_active == 5'd0 && n_entries > 5'd0) begin
              // group commit: copy out, header, install home, clear header
              for (int i = 0; i < n_entries; i++)
                push(rlog_pkg::ST_OK, rlog_pkg::ACT_COPY, blocks[i], log_start + 32'd1 + i,
                     5'd0, rlog_pkg::HOLD_NONE);
              push(rlog_pkg::ST_OK, rlog_pkg::ACT_HEADER, log_start, log_start, n_entries,
                   rlog_pkg::HOLD_NONE);
              for (int i = 0; i < n_entries; i++)
                push(rlog_pkg::ST_OK, rlog_pkg::ACT_INSTALL, log_start + 32'd1 + i,
                     blocks[i], 5'd0, rlog_pkg::HOLD_UNPIN);
              push(rlog_pkg::ST_OK, rlog_pkg::ACT_HEADER, log_start, log_start, 5'd0,
                   rlog_pkg::HOLD_NONE);
              n_entries = 5'd0;
            end else begin
              push(rlog_pkg::ST_OK, rlog_pkg::ACT_NONE, 32'd0, 32'd0, 5'd0,
                   rlog_pkg::HOLD_NONE);
            end
          end
        end
        rlog_pkg::CMD_RECORD: begin
          found = 1'b0;
          if (n_entries >= LOG_CAP ||
              (33'(n_entries) + 33'd1) >= {1'b0, region_len}) begin
            push(rlog_pkg::ST_FULL, rlog_pkg::ACT_NONE, 32'd0, 32'd0, 5'd0,
                 rlog_pkg::HOLD_NONE);
          end else if (n_active == 5'd0) begin
            push(rlog_pkg::ST_OUTSIDE, rlog_pkg::ACT_NONE, 32'd0, 32'd0, 5'd0,
                 rlog_pkg::HOLD_NONE);
          end else begin
            for (int i = 0; i < n_entries; i++)
              if (blocks[i] == blk) found = 1'b1;
            if (found) begin
              push(rlog_pkg::ST_OK, rlog_pkg::ACT_NONE, blk, 32'd0, 5'd0,
                   rlog_pkg::HOLD_NONE);
            end else begin
              blocks[n_entries] = blk;
              n_entries++;
              push(rlog_pkg::ST_OK, rlog_pkg::ACT_NONE, blk, 32'd0, 5'd0,
                   rlog_pkg::HOLD_PIN);
            end
          end
        end
        default: push(rlog_pkg::ST_OK, rlog_pkg::ACT_NONE, 32'd0, 32'd0, 5'd0,
                      rlog_pkg::HOLD_NONE);
      endcase
      pending[pending.size() - 1].last = 1'b1;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // Compare one accepted result item with the oldest expectation
    function void check_result(logic [79:0] data, logic tlast);
      log_result_t e;
      if (pending.size() == 0) begin
        $error("result item 0x%0h arrived with nothing expected", data);
        errors++;
        return;
      end
      e = pending.pop_front();
      compare_field("status", e.status, data[2:0]);
      compare_field("action", e.action, data[4:3]);
      compare_field("source_block", e.src_blk, data[36:5]);
      compare_field("dest_block", e.dst_blk, data[68:37]);
      compare_field("header_count", e.hdr_count, data[73:69]);
      compare_field("cache_hold", e.hold, data[75:74]);
      compare_field("last", e.last, tlast);
    endfunction

    function void check_drained();
      if (pending.size() != 0) begin
        $error("%0d expected result items never arrived", pending.size());
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // cmd[1:0], block_number[33:2], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;       // status, action, source_block, dest_block,
                                   // header_count, cache_hold, zero pad
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  rlog_pkg::reg_idx_t cfg_index = rlog_pkg::REG_LOG_START;
  logic [31:0] cfg_data = '0;

  commit_tracker tracker = new();
  bit            steady_phase = 1'b0;
  int            items_sent = 0;
  int            idle_cycles = 0;

  redo_log_transaction_manager_core #(
    .LOG_CAPACITY(LOG_CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, none in a steady phase
  function automatic int pick_gap();
    int r;
    if (steady_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Stall the result channel at random
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  // Check every accepted result item
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      tracker.check_result(m_axis_tdata, m_axis_tlast);
  end

  // End the run if nothing moves for too long
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("redo_log_transaction_manager_core_tb: errors");
      $finish;
    end
  end

  // Offer one request item and hold it until accepted
  task automatic send_request(rlog_pkg::cmd_t op, logic [31:0] blk);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, blk, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    tracker.note_request(op, blk);
    if (op != rlog_pkg::CMD_NOP) items_sent++;
  endtask

  // Drop the request and hold off until every expected item has come
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (tracker.pending.size() > 0) @(posedge clk);
  endtask

  task automatic write_register(rlog_pkg::reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.write_reg(idx, value);
  endtask

  function automatic logic [31:0] pick_block(logic [31:0] pool[8]);
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return pool[$urandom_range(0, 7)];
    else if (r == 5) return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
    else return $urandom();
  endfunction

  // One group of operations: begins, records with repeats, ends, some noise
  task automatic run_transaction();
    logic [31:0] pool[8];
    int          n_rec;
    foreach (pool[i]) pool[i] = $urandom();
    repeat ($urandom_range(1, 4)) send_request(rlog_pkg::CMD_BEGIN, $urandom());
    n_rec = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 34) : $urandom_range(0, 8);
    repeat (n_rec) begin
      if ($urandom_range(0, 9) == 0)
        send_request(rlog_pkg::cmd_t'($urandom_range(0, 3)), $urandom());
      else
        send_request(rlog_pkg::CMD_RECORD, pick_block(pool));
    end
    while (tracker.n_active > 0) begin
      if ($urandom_range(0, 7) == 0)
        send_request(rlog_pkg::CMD_RECORD, pick_block(pool));
      else
        send_request(rlog_pkg::CMD_END, $urandom());
    end
    if ($urandom_range(0, 5) == 0) send_request(rlog_pkg::CMD_END, $urandom());
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Default settings: stray requests, admission limit, absorption, commit
    send_request(rlog_pkg::CMD_END, 32'd0);
    send_request(rlog_pkg::CMD_RECORD, 32'hFFFF_FFFF);
    send_request(rlog_pkg::CMD_NOP, 32'h5A5A_5A5A);
    send_request(rlog_pkg::CMD_BEGIN, 32'd0);
    send_request(rlog_pkg::CMD_BEGIN, 32'd0);
    send_request(rlog_pkg::CMD_BEGIN, 32'd0);
    send_request(rlog_pkg::CMD_BEGIN, 32'd0);
    send_request(rlog_pkg::CMD_RECORD, 32'd0);
    send_request(rlog_pkg::CMD_RECORD, 32'hFFFF_FFFF);
    send_request(rlog_pkg::CMD_RECORD, 32'd0);
    send_request(rlog_pkg::CMD_RECORD, 32'hA5A5_A5A5);
    send_request(rlog_pkg::CMD_END, 32'd0);
    send_request(rlog_pkg::CMD_END, 32'd0);
    send_request(rlog_pkg::CMD_END, 32'd0);
    send_request(rlog_pkg::CMD_BEGIN, 32'd0);
    send_request(rlog_pkg::CMD_END, 32'd0);

    // Tiny log region, widest op, slot address at the top of the block range
    wait_drained();
    write_register(rlog_pkg::REG_LOG_START, 32'hFFFF_FFFE);
    write_register(rlog_pkg::REG_LOG_LENGTH, 32'd2);
    write_register(rlog_pkg::REG_MAX_PER_OP, 32'd30);
    send_request(rlog_pkg::CMD_BEGIN, 32'd0);
    send_request(rlog_pkg::CMD_BEGIN, 32'd0);
    send_request(rlog_pkg::CMD_RECORD, 32'h1234_5678);
    send_request(rlog_pkg::CMD_RECORD, 32'd0);
    send_request(rlog_pkg::CMD_END, 32'd0);

    wait_drained();
    write_register(rlog_pkg::REG_LOG_START, 32'd0);
    write_register(rlog_pkg::REG_LOG_LENGTH, 32'hFFFF_FFFF);
    write_register(rlog_pkg::REG_MAX_PER_OP, 32'd1);

    // Random phases, each with its own settings
    while (items_sent < ITEM_TARGET) begin
      wait_drained();
      steady_phase = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 4))
          0: write_register(rlog_pkg::REG_LOG_START, 32'd0);
          1: write_register(rlog_pkg::REG_LOG_START, 32'hFFFF_FFFF);
          2: write_register(rlog_pkg::REG_LOG_START, 32'hFFFF_FFF0);
          default: write_register(rlog_pkg::REG_LOG_START, $urandom());
        endcase
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 6))
          0: write_register(rlog_pkg::REG_LOG_LENGTH, 32'd2);
          1: write_register(rlog_pkg::REG_LOG_LENGTH, 32'd3);
          2: write_register(rlog_pkg::REG_LOG_LENGTH, 32'd31);
          3: write_register(rlog_pkg::REG_LOG_LENGTH, 32'hFFFF_FFFF);
          4: write_register(rlog_pkg::REG_LOG_LENGTH, $urandom());
          default: write_register(rlog_pkg::REG_LOG_LENGTH, $urandom_range(2, 40));
        endcase
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 3))
          0: write_register(rlog_pkg::REG_MAX_PER_OP, 32'd1);
          1: write_register(rlog_pkg::REG_MAX_PER_OP, 32'd30);
          default: write_register(rlog_pkg::REG_MAX_PER_OP, $urandom_range(1, 30));
        endcase
      end
      repeat ($urandom_range(1, 4)) run_transaction();
    end

    // Drain, allow one full commit of slack, then report
    wait_drained();
    repeat (2 * LOG_CAP + 10) @(posedge clk);
    tracker.check_drained();
    if (tracker.errors == 0)
      $display("redo_log_transaction_manager_core_tb: clean");
    else
      $display("redo_log_transaction_manager_core_tb: errors");
    $finish;
  end

endmodule

/* files.f */
design/rlog_pkg.sv
design/rlog_cell.sv
design/redo_log_transaction_manager_core.sv
test/redo_log_transaction_manager_core_tb.sv
